[design/packet_frame_completion_tracker_assert.svh]
// Assertion macros for the tracker
`ifndef PACKET_FRAME_COMPLETION_TRACKER_ASSERT_SVH
`define PACKET_FRAME_COMPLETION_TRACKER_ASSERT_SVH
`define PFCT_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PFCT_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[design/pfct_pkg.sv]
package pfct_pkg;
    localparam int GROUPS_DEF = 4;
    localparam int FRAMES_DEF = 40;
    localparam int PKTS_DEF = 128;
    localparam int CHANNELS_DEF = 16;
    localparam int MAX_RESULTS = 4;
    localparam int FC_W = 40;

    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;
    localparam logic [1:0] REQ_RSVD = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_BEFORE = 3'd2;
    localparam logic [2:0] ST_AHEAD = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;
    localparam logic [2:0] ST_BAD = 3'd6;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [1:0]  group_index;
        logic [39:0] frame_count;
        logic        packet_invalid;
        logic [3:0]  channel;
        logic [2:0]  board;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  slot;
        logic [12:0] store_position;
        logic        group_full;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        K_IMM,
        K_INIT,
        K_QUERY,
        K_INSERT
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  status;
        logic [1:0]  group_index;
        logic [39:0] frame_count;
        logic [3:0]  channel;
        logic [2:0]  board;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_SEARCH,
        S_CHECK,
        S_RDWAIT,
        S_RDDATA,
        S_UPDATE,
        S_EMIT,
        S_NEXT,
        S_FINAL
    } t_state;
endpackage

[design/pfct_front.sv]
module pfct_front
    import pfct_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_q_valid,
    input  logic i_q_pop,
    output t_cmd o_q_cmd
);
    t_cmd r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd n_cmd;
    logic push;

    always_comb begin
        n_cmd = '0;
        n_cmd.kind = K_IMM;
        n_cmd.status = ST_BAD;
        n_cmd.group_index = i_data.group_index;
        n_cmd.frame_count = i_data.frame_count;
        n_cmd.channel = i_data.channel;
        n_cmd.board = i_data.board;
        if (32'(i_data.group_index) >= GROUPS || i_data.req_type == REQ_RSVD ||
            (i_data.req_type == REQ_INSERT && 32'(i_data.channel) >= CHANNELS)) begin
            n_cmd.status = ST_BAD;
        end else if (i_data.req_type == REQ_INIT) begin
            n_cmd.kind = K_INIT;
            n_cmd.status = ST_DONE;
        end else if (i_data.req_type == REQ_QUERY) begin
            n_cmd.kind = K_QUERY;
            n_cmd.status = ST_DONE;
        end else if (i_data.packet_invalid) begin
            n_cmd.status = ST_INVALID;
        end else begin
            n_cmd.kind = K_INSERT;
        end
    end

    assign o_stall = (r_cnt == 2'd2);
    assign push = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

[design/pfct_back.sv]
module pfct_back
    import pfct_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int FRAMES = FRAMES_DEF,
    parameter int PKTS_PER_FRAME = PKTS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    output logic o_q_pop,
    input  t_cmd i_q_cmd,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int FW = $clog2(FRAMES);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NF = GROUPS * FRAMES;
    localparam int NFW = $clog2(NF);
    localparam int NCB = NF * CHANNELS;
    localparam int NCBW = $clog2(NCB);
    localparam int OW = $clog2(GROUPS + 1);
    localparam int PW = $clog2(PKTS_PER_FRAME + 1);
    localparam int TW = $clog2(FRAMES * PKTS_PER_FRAME + 1);
    localparam int CLW = $clog2(NCB + 1);
    localparam logic [TW-1:0] FULL_CNT = TW'(FRAMES * PKTS_PER_FRAME);
    localparam logic [FC_W:0] STEP = (FC_W + 1)'(FRAMES - 1);
    localparam logic [CLW-1:0] CLR_LAST = CLW'(FRAMES * CHANNELS - 1);

    logic [FC_W-1:0] r_base [GROUPS];
    logic [TW-1:0]   r_gtot [GROUPS];
    logic [PW-1:0]   r_fmem [NF];
    logic [7:0]      r_cmem [NCB];

    t_state r_st, n_st;
    t_cmd r_cmd;
    logic [FC_W:0] r_ll;
    logic [OW-1:0] r_i;
    logic [2:0] r_n;
    logic [CLW-1:0] r_clr;
    logic [GW-1:0] r_g;
    logic [FW-1:0] r_fi;
    logic [PW-1:0] r_fcnt;
    logic [7:0] r_flags;
    logic r_ovalid;
    t_out r_odata;
    t_out r_pend;

    logic [FC_W:0] b, lu, lo, hi;
    logic [GW-1:0] g_cur;
    logic [31:0] g_sum;
    logic [NFW-1:0] fidx;
    logic [NCBW-1:0] cidx, clr_idx;
    logic out_free, hit, ok, out_load;
    logic [FC_W:0] fi_wide;

    function automatic t_out out_item(input logic [2:0] st, input logic [1:0] sl,
                                      input logic [12:0] pos, input logic full,
                                      input logic lst);
        t_out r;
        r.status = st;
        r.slot = sl;
        r.store_position = pos;
        r.group_full = full;
        r.last = lst;
        return r;
    endfunction

    assign out_free = !r_ovalid || !i_stall;
    assign b = {1'b0, r_cmd.frame_count};
    assign lu = r_ll + STEP;
    assign g_sum = 32'(r_i) + 32'(r_cmd.group_index);
    assign g_cur = GW'((g_sum >= 32'(GROUPS)) ? g_sum - 32'(GROUPS) : g_sum);
    assign lo = {1'b0, r_base[g_cur]};
    assign hi = lo + STEP;
    assign hit = (b >= lo) && (b <= hi);
    assign fi_wide = b - lo;
    assign fidx = NFW'(32'(r_g) * FRAMES + 32'(r_fi));
    assign cidx = NCBW'(32'(fidx) * CHANNELS + 32'(r_cmd.channel[CW-1:0]));
    assign clr_idx = NCBW'(32'(r_cmd.group_index) * FRAMES * CHANNELS + 32'(r_clr));
    assign ok = (r_fcnt < PW'(PKTS_PER_FRAME)) && (r_gtot[r_g] < FULL_CNT);
    assign o_valid = r_ovalid;
    assign o_data = r_odata;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    unique case (i_q_cmd.kind)
                        K_INIT:   n_st = S_CLEAR;
                        K_INSERT: n_st = S_SEARCH;
                        default:  n_st = S_IDLE;
                    endcase
                end
            end
            S_CLEAR: begin
                if (r_clr == CLR_LAST) begin
                    if (r_cmd.kind == K_INIT) begin
                        n_st = S_FINAL;
                    end else if (32'(r_cmd.group_index) == GROUPS - 1) begin
                        n_st = S_IDLE;
                    end
                end
            end
            S_SEARCH: begin
                if (b < {1'b0, r_base[r_cmd.group_index]}) begin
                    n_st = S_FINAL;
                end else if ((b >= r_ll && b <= lu) || r_i == OW'(GROUPS - 1)) begin
                    n_st = (!(b >= r_ll && b <= lu) &&
                            b > lu + STEP + (FC_W + 1)'(FRAMES)) ? S_FINAL : S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_i == OW'(GROUPS) || r_n == 3'(MAX_RESULTS)) begin
                    n_st = S_FINAL;
                end else if (hit) begin
                    n_st = S_RDWAIT;
                end else begin
                    n_st = S_CHECK;
                end
            end
            S_RDWAIT: n_st = S_RDDATA;
            S_RDDATA: n_st = ok ? S_UPDATE : S_NEXT;
            S_UPDATE: n_st = S_EMIT;
            S_EMIT:   n_st = (r_n == 3'd1 || out_free) ? S_NEXT : S_EMIT;
            S_NEXT:   n_st = S_CHECK;
            S_FINAL:  n_st = out_free ? S_IDLE : S_FINAL;
            default:  n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop = (r_st == S_IDLE) && i_q_valid && out_free;
        out_load = (o_q_pop && (i_q_cmd.kind == K_IMM || i_q_cmd.kind == K_QUERY)) ||
                   (r_st == S_EMIT && out_free && r_n != 3'd1) ||
                   (r_st == S_FINAL && out_free);
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_RDWAIT) begin
            r_fcnt <= r_fmem[fidx];
            r_flags <= r_cmem[cidx];
        end
        if (r_st == S_CLEAR) begin
            r_cmem[clr_idx] <= 8'h00;
            if (r_clr < CLW'(FRAMES)) begin
                r_fmem[NFW'(32'(r_cmd.group_index) * FRAMES + 32'(r_clr))] <= '0;
            end
        end
        if (r_st == S_UPDATE) begin
            r_fmem[fidx] <= r_fcnt + PW'(1);
            r_cmem[cidx] <= r_flags | (8'h01 << r_cmd.board);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_ovalid <= 1'b0;
            r_clr <= '0;
            r_cmd <= '0;
            for (int k = 0; k < GROUPS; k++) begin
                r_base[k] <= '0;
                r_gtot[k] <= '0;
            end
        end else begin
            r_st <= n_st;
            r_ovalid <= out_load || (r_ovalid && i_stall);
            unique case (r_st)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_cmd <= i_q_cmd;
                        r_clr <= '0;
                        r_i <= '0;
                        r_n <= '0;
                        r_ll <= {1'b0, r_base[i_q_cmd.group_index]};
                        if (i_q_cmd.kind == K_INIT) begin
                            r_base[i_q_cmd.group_index] <= i_q_cmd.frame_count;
                            r_gtot[i_q_cmd.group_index] <= '0;
                        end
                        if (i_q_cmd.kind == K_IMM || i_q_cmd.kind == K_QUERY) begin
                            r_odata <= out_item(i_q_cmd.status, '0, '0,
                                (i_q_cmd.kind == K_QUERY) &&
                                (r_gtot[i_q_cmd.group_index] == FULL_CNT), 1'b1);
                        end
                    end
                end
                S_CLEAR: begin
                    if (r_clr == CLR_LAST) begin
                        r_clr <= '0;
                        if (r_cmd.kind != K_INIT) begin
                            r_cmd.group_index <= r_cmd.group_index + 2'd1;
                        end
                    end else begin
                        r_clr <= r_clr + CLW'(1);
                    end
                end
                S_SEARCH: begin
                    if (b < {1'b0, r_base[r_cmd.group_index]}) begin
                        r_cmd.status <= ST_BEFORE;
                    end else if (n_st == S_FINAL) begin
                        r_cmd.status <= ST_AHEAD;
                    end else if (n_st == S_SEARCH) begin
                        r_ll <= lu;
                        r_i <= r_i + OW'(1);
                    end
                    if (n_st == S_CHECK) begin
                        r_cmd.status <= ST_NONE;
                    end
                end
                S_CHECK: begin
                    if (n_st == S_CHECK) begin
                        r_i <= r_i + OW'(1);
                    end
                    r_g <= g_cur;
                    r_fi <= FW'(fi_wide);
                end
                S_RDDATA: begin
                    if (ok) begin
                        r_gtot[r_g] <= r_gtot[r_g] + TW'(1);
                    end
                end
                S_UPDATE: begin
                    r_n <= r_n + 3'd1;
                end
                S_EMIT: begin
                    if (r_n == 3'd1 || out_free) begin
                        r_pend <= out_item(ST_INSERTED, 2'(r_g),
                                           13'(r_gtot[r_g] - TW'(1)), 1'b0, 1'b0);
                        if (r_n != 3'd1) begin
                            r_odata <= r_pend;
                        end
                    end
                end
                S_NEXT: begin
                    r_i <= r_i + OW'(1);
                end
                S_FINAL: begin
                    if (out_free) begin
                        r_odata <= (r_cmd.kind == K_INIT || r_n == 3'd0)
                            ? out_item(r_cmd.status, '0, '0, 1'b0, 1'b1)
                            : out_item(r_pend.status, r_pend.slot,
                                       r_pend.store_position, 1'b0, 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

[design/packet_frame_completion_tracker.sv]
// Packet frame completion tracker.
// Input channel i_valid/o_stall carries one request item (init, insert,
// query) as a t_in struct; output channel o_valid/i_stall returns t_out
// result items, the final one of each request marked by last.
// A front stage classifies requests into a two-entry queue; a back
// sequencer executes them against the slot bases, counters and flag memory.
// Init and query answer one result: query as soon as it leaves the queue,
// init after a sweep of FRAMES*CHANNELS entries (640 by default).
// Insert scans up to GROUPS search ranges (one per cycle), then checks each
// slot in ring order: a matching slot is read and, unless it or its group
// is full, updated and emitted, else skipped; then the last result is sent.
// Results of an insert are emitted in ring order, at most four.
// Reset clears slot bases and totals, then sweeps the frame and flag memory
// (GROUPS*FRAMES*CHANNELS entries, 2560 by default) before the first item.
// When the receiver stalls, the output register holds its item, the
// sequencer waits, and the queue fills and then stalls the sender.
module packet_frame_completion_tracker
    import pfct_pkg::*;
#(
    parameter int GROUPS = GROUPS_DEF,
    parameter int FRAMES = FRAMES_DEF,
    parameter int PKTS_PER_FRAME = PKTS_DEF,
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);
`include "packet_frame_completion_tracker_assert.svh"
    logic q_valid, q_pop;
    t_cmd q_cmd;

    pfct_front #(.GROUPS(GROUPS), .CHANNELS(CHANNELS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    pfct_back #(.GROUPS(GROUPS), .FRAMES(FRAMES), .PKTS_PER_FRAME(PKTS_PER_FRAME),
        .CHANNELS(CHANNELS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(q_valid), .o_q_pop(q_pop),
        .i_q_cmd(q_cmd), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    `PFCT_ASSERT_IMPL(a_pop_valid, i_clk, i_rst_n, q_pop, q_valid)
    `PFCT_ASSERT_IMPL(a_ins_slot, i_clk, i_rst_n,
        o_valid && o_data.status == ST_INSERTED, !o_data.group_full)
    `PFCT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_data))
endmodule
